// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the display command encoder.
// Users need a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge outside reset.
`define SSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define SSD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: src/ssdce_pkg.sv
// Package for the seven-segment display command encoder: payload types, codes,
// command constants and the glyph functions. Depends on nothing.
`default_nettype none

package ssdce_pkg;

  localparam int DIGIT_COUNT_DEF = 4;
  localparam int MAG_W           = 32;
  localparam int WORD_W          = 32;
  localparam int BCD_DIGITS      = 10;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int DCNT_W          = $clog2(BCD_DIGITS + 1);
  localparam int SCNT_W          = $clog2(MAG_W);
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 3;

  localparam logic [2:0] FUNC_NUMBER = 3'd0;
  localparam logic [2:0] FUNC_LEFT   = 3'd1;
  localparam logic [2:0] FUNC_RIGHT  = 3'd2;
  localparam logic [2:0] FUNC_BOTH   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLON      = 1'b1;

  localparam logic [7:0] CMD_WRITEMODE  = 8'h40;
  localparam logic [7:0] CMD_ADDRESS    = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;
  localparam logic [7:0] GLYPH_MINUS    = 8'h40;
  localparam logic [7:0] GLYPH_ZERO     = 8'b00111111;
  localparam logic [7:0] GLYPH_BLANK    = 8'h00;
  localparam logic [6:0] PAIR_MAX       = 7'd99;

  localparam logic [WORD_W-1:0] CLR_WORD0 = 32'h0000_0080;
  localparam logic [WORD_W-1:0] CLR_WORD1 = 32'h0000_C040;
  localparam logic [WORD_W-1:0] CLR_WORD2 = 32'h0000_0000;

  typedef struct packed {
    logic [2:0]        func;
    logic signed [31:0] number;
    logic              leading_zeros;
    logic [6:0]        left_value;
    logic [6:0]        right_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] command_word;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic [DCNT_W-1:0] count;
  } b2d_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } top_state_e;

  typedef enum logic [1:0] {
    B2D_IDLE,
    B2D_SHIFT,
    B2D_NORM
  } b2d_state_e;

  typedef enum logic [1:0] {
    KIND_PUT4,
    KIND_PUT2,
    KIND_CLEAR
  } word_kind_e;

  function automatic logic [7:0] seg_glyph(input logic [3:0] digit);
    logic [7:0] g;
    unique case (digit)
      4'd0:    g = 8'b00111111;
      4'd1:    g = 8'b00000110;
      4'd2:    g = 8'b01011011;
      4'd3:    g = 8'b01001111;
      4'd4:    g = 8'b01100110;
      4'd5:    g = 8'b01101101;
      4'd6:    g = 8'b01111101;
      4'd7:    g = 8'b00000111;
      4'd8:    g = 8'b01111111;
      4'd9:    g = 8'b01101111;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

  // Two glyph bytes for a digit pair: tens in the low byte, colon on bit 15.
  function automatic logic [15:0] pair_glyphs(input logic [6:0] val, input logic lz,
                                              input logic colon);
    logic [6:0]  v;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    logic [7:0]  lo;
    logic [7:0]  hi;
    v    = (val > PAIR_MAX) ? PAIR_MAX : val;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    ones = v - ({3'd0, tens} * 7'd10);
    hi   = seg_glyph(ones[3:0]) | {colon, 7'd0};
    lo   = ((tens != 4'd0) || lz) ? seg_glyph(tens) : GLYPH_BLANK;
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

// File: src/ssdce_b2d.sv
// Bit-serial binary to decimal converter with leading-digit normalisation.
// Uses ssdce_pkg for widths, state type and status struct.
`default_nettype none

module ssdce_b2d
  import ssdce_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [MAG_W-1:0]           value_i,
  output      b2d_stat_t                  stat_o,
  output      logic [4*DIGIT_COUNT-1:0]   digits_o
);

  b2d_state_e          state_q, state_d;
  logic [SCNT_W-1:0]   cnt_q;
  logic [DCNT_W-1:0]   norm_q;
  logic [MAG_W-1:0]    bin_q;
  logic [BCD_W-1:0]    bcd_q;
  logic [BCD_W-1:0]    bcd_adj;
  logic                finish;

  assign finish = (bcd_q[BCD_W-1 -: 4] != 4'd0) || (norm_q == DCNT_W'(BCD_DIGITS));

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < BCD_DIGITS; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? (bcd_q[4*k +: 4] + 4'd3)
                                                   : bcd_q[4*k +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B2D_IDLE:  if (start_i) state_d = B2D_SHIFT;
      B2D_SHIFT: if (cnt_q == SCNT_W'(MAG_W - 1)) state_d = B2D_NORM;
      B2D_NORM:  if (finish) state_d = B2D_IDLE;
      default:   state_d = B2D_IDLE;
    endcase
  end

  always_comb begin
    stat_o.done  = (state_q == B2D_NORM) && finish;
    stat_o.count = DCNT_W'(BCD_DIGITS) - norm_q;
    digits_o     = bcd_q[BCD_W-1 -: 4*DIGIT_COUNT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B2D_IDLE;
      cnt_q   <= '0;
      norm_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B2D_IDLE && start_i) begin
        cnt_q  <= '0;
        norm_q <= '0;
      end else if (state_q == B2D_SHIFT) begin
        cnt_q <= cnt_q + SCNT_W'(1);
      end else if (state_q == B2D_NORM && !finish) begin
        norm_q <= norm_q + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B2D_IDLE && start_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (state_q == B2D_SHIFT) begin
      bin_q <= {bin_q[MAG_W-2:0], 1'b0};
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[MAG_W-1]};
    end else if (state_q == B2D_NORM && !finish) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
    end
  end

endmodule

`default_nettype wire

// File: src/seven_segment_display_command_encoder.sv
// Top level of the seven-segment display command encoder: command decode,
// glyph assembly and word sequencing. Uses ssdce_pkg and ssdce_b2d.
//
//   channel  | direction | payload     | handshake
//   ---------+-----------+-------------+---------------------------------
//   in       | input     | in_item_t   | in_valid_i / in_stall_o
//   out      | output    | out_item_t  | out_valid_o / out_stall_i
//   cfg      | input     | cfg_data_i  | cfg_we_i, index cfg_idx_i
//
// One command at a time. A number command passes through the bit-serial
// decimal converter and then the leading-digit search before its first
// word can transfer. Pair and clear commands can transfer their first word
// in the cycle after the command's transfer.
// Each output word then waits for its transfer; out_stall_i holds the word.
// in_stall_o stays high from the transfer until the final word has gone;
// spare function codes are accepted and dropped without any word.
// Reset clears the sequencer and sets brightness 0 with the colon enabled.
`default_nettype none

module seven_segment_display_command_encoder
  import ssdce_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_item_t              in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_item_t             out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "assert_macros.svh"

  localparam int LEN_W   = $clog2(DIGIT_COUNT + 1);
  localparam int START_W = $clog2(DIGIT_COUNT);

  top_state_e                 state_q, state_d;
  word_kind_e                 kind_q;
  logic [1:0]                 idx_q;
  logic [WORD_W-1:0]          hex_q;
  logic [START_W-1:0]         start_q;
  logic                       neg_q;
  logic                       lz_q;
  logic [2:0]                 bright_q;
  logic                       colon_q;

  logic                       in_xfer;
  logic                       out_xfer;
  logic                       word_last;
  logic                       conv_start;
  logic [MAG_W-1:0]           mag;
  b2d_stat_t                  conv_stat;
  logic [4*DIGIT_COUNT-1:0]   conv_digits;

  logic [WORD_W-1:0]          num_raw;
  logic [WORD_W-1:0]          num_hex;
  logic [START_W-1:0]         num_start;
  logic [LEN_W-1:0]           cap;
  logic [LEN_W-1:0]           len;
  logic [LEN_W-1:0]           pad;
  logic [LEN_W-1:0]           src;
  logic [DCNT_W-1:0]          ndig;
  logic [7:0]                 on_byte;
  logic [7:0]                 addr_byte;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign conv_start = in_xfer && (in_data_i.func == FUNC_NUMBER);
  assign mag        = in_data_i.number[31] ? (MAG_W'(0) - $unsigned(in_data_i.number))
                                           : $unsigned(in_data_i.number);

  ssdce_b2d #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_b2d (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .value_i  (mag),
    .stat_o   (conv_stat),
    .digits_o (conv_digits)
  );

  // Assemble the number's glyph bytes: leftmost digit in the lowest byte,
  // a minus sign ahead of at most DIGIT_COUNT - 1 digits, then pad or right-align.
  always_comb begin
    ndig = conv_stat.count;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      num_raw[8*k +: 8] = GLYPH_BLANK;
      if (neg_q) begin
        if (k == 0) begin
          num_raw[8*k +: 8] = GLYPH_MINUS;
        end else if (DCNT_W'(k - 1) < ndig) begin
          num_raw[8*k +: 8] = seg_glyph(conv_digits[4*(DIGIT_COUNT-k) +: 4]);
        end
      end else if (DCNT_W'(k) < ndig) begin
        num_raw[8*k +: 8] = seg_glyph(conv_digits[4*(DIGIT_COUNT-1-k) +: 4]);
      end
    end
    cap = neg_q ? LEN_W'(DIGIT_COUNT - 1) : LEN_W'(DIGIT_COUNT);
    len = ((ndig > DCNT_W'(cap)) ? cap : ndig[LEN_W-1:0]) + LEN_W'(neg_q);
    pad = LEN_W'(DIGIT_COUNT) - len;

    num_hex   = num_raw;
    num_start = '0;
    src       = '0;
    if (lz_q && (len < LEN_W'(DIGIT_COUNT))) begin
      // zero glyphs fill the left, the rest moves right by the pad count
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        src = LEN_W'(k) - pad;
        if (LEN_W'(k) < pad) begin
          num_hex[8*k +: 8] = GLYPH_ZERO;
        end else begin
          num_hex[8*k +: 8] = num_raw[8*src[START_W-1:0] +: 8];
        end
      end
    end else if (ndig == '0) begin
      num_hex   = {{(WORD_W - 8){1'b0}}, GLYPH_ZERO};
      num_start = START_W'(DIGIT_COUNT - 1);
    end else begin
      num_start = pad[START_W-1:0];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.func) inside
            FUNC_NUMBER:              state_d = ST_CONV;
            [FUNC_LEFT:FUNC_CLEAR]:   state_d = ST_EMIT;
            default:                  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CONV: if (conv_stat.done) state_d = ST_EMIT;
      ST_EMIT: if (out_xfer && word_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: the word is picked from held registers, so it is
  // stable while stalled unless the brightness register is written.
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    on_byte     = CMD_DISPLAY_ON + {5'd0, bright_q};
    addr_byte   = CMD_ADDRESS + 8'(start_q);
    word_last   = 1'b0;
    out_data_o.command_word = '0;
    unique case (kind_q)
      KIND_PUT4: begin
        word_last = (idx_q == 2'd2);
        case (idx_q)
          2'd0:    out_data_o.command_word = {hex_q[15:0], addr_byte, CMD_WRITEMODE};
          2'd1:    out_data_o.command_word = {hex_q[31:16], 16'd0};
          default: out_data_o.command_word = {24'd0, on_byte};
        endcase
      end
      KIND_PUT2: begin
        word_last = (idx_q == 2'd1);
        case (idx_q)
          2'd0:    out_data_o.command_word = {hex_q[15:0], addr_byte, CMD_WRITEMODE};
          default: out_data_o.command_word = {24'd0, on_byte};
        endcase
      end
      KIND_CLEAR: begin
        word_last = (idx_q == 2'd2);
        case (idx_q)
          2'd0:    out_data_o.command_word = CLR_WORD0;
          2'd1:    out_data_o.command_word = CLR_WORD1;
          default: out_data_o.command_word = CLR_WORD2;
        endcase
      end
      default: word_last = 1'b1;
    endcase
    out_data_o.last = word_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      bright_q <= '0;
      colon_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        idx_q <= '0;
      end else if (out_xfer) begin
        idx_q <= idx_q + 2'd1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_BRIGHTNESS: bright_q <= cfg_data_i;
          CFG_COLON:      colon_q  <= cfg_data_i[0];
          default:        ;
        endcase
      end
    end
  end

  // Command payload: capture on transfer, refill once the number is decoded
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      neg_q   <= in_data_i.number[31];
      lz_q    <= in_data_i.leading_zeros;
      start_q <= '0;
      hex_q   <= '0;
      kind_q  <= KIND_PUT4;
      case (in_data_i.func)
        FUNC_LEFT: begin
          kind_q <= KIND_PUT2;
          hex_q  <= {16'd0, pair_glyphs(in_data_i.left_value, in_data_i.leading_zeros,
                                        colon_q)};
        end
        FUNC_RIGHT: begin
          kind_q  <= KIND_PUT2;
          start_q <= START_W'(2);
          hex_q   <= {16'd0, pair_glyphs(in_data_i.right_value, in_data_i.leading_zeros,
                                         1'b0)};
        end
        FUNC_BOTH: begin
          hex_q <= {pair_glyphs(in_data_i.right_value, in_data_i.leading_zeros, 1'b0),
                    pair_glyphs(in_data_i.left_value, in_data_i.leading_zeros, colon_q)};
        end
        FUNC_CLEAR: kind_q <= KIND_CLEAR;
        default:    kind_q <= KIND_PUT4;
      endcase
    end else if (state_q == ST_CONV && conv_stat.done) begin
      hex_q   <= num_hex;
      start_q <= num_start;
    end
  end

  `SSD_ASSERT(a_busy_while_emitting, out_valid_o |-> in_stall_o, "command taken mid sequence")
  `SSD_ASSERT(a_conv_done_in_conv, conv_stat.done |-> (state_q == ST_CONV), "stray result")
  `SSD_ASSERT(a_last_ends_sequence, (out_xfer && out_data_o.last) |=> !out_valid_o, "word after last")
  `SSD_ASSERT_NEVER(a_put2_overrun, out_valid_o && kind_q == KIND_PUT2 && idx_q == 2'd2, "overrun")

endmodule

`default_nettype wire

// File: dv/seven_segment_display_command_encoder_test.sv
// Self-checking testbench for seven_segment_display_command_encoder: drives commands,
// register settings and output stalls, and checks every command word against a predictor.
// Depends on ssdce_pkg and the encoder RTL only.

module seven_segment_display_command_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssdce_pkg::*;

  // Quiet cycles (no transfer on either channel) before the run is declared hung.
  localparam int QUIET_LIMIT    = 2000;
  // Settle time once no word is awaited, before new register settings are
  // written or the run ends.
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_COMMANDS = 56;
  localparam int DIGITS         = 4;

  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // Predicts the controller words of each command and holds them until they arrive.
  class segment_word_scoreboard;
    bit [2:0]  level;
    bit        colon_on;
    out_item_t awaited[$];
    int        mismatches;
    int        words_checked;
    int        commands_seen;
    int        ignored_seen;

    function new();
      level         = 3'd0;
      colon_on      = 1'b1;
      mismatches    = 0;
      words_checked = 0;
      commands_seen = 0;
      ignored_seen  = 0;
    endfunction

    function bit [7:0] digit_segments(int d);
      case (d)
        0: return 8'h3F;
        1: return 8'h06;
        2: return 8'h5B;
        3: return 8'h4F;
        4: return 8'h66;
        5: return 8'h6D;
        6: return 8'h7D;
        7: return 8'h07;
        8: return 8'h7F;
        9: return 8'h6F;
        default: return 8'h00;
      endcase
    endfunction

    // Most significant digit lands in the low byte; digits past the fourth
    // fall off the top, so only the leading four survive.
    function bit [31:0] glyph_string(bit [31:0] v);
      bit [31:0] h;
      h = '0;
      if (v == 0) return {24'd0, digit_segments(0)};
      while (v != 0) begin
        h = {h[23:0], digit_segments(int'(v % 10))};
        v = v / 10;
      end
      return h;
    endfunction

    // Tens in the low byte, units in the high byte, colon on the top bit.
    function bit [15:0] pair_segments(bit [6:0] raw, bit lz, bit colon);
      bit [6:0]  v;
      bit [15:0] h;
      v = (raw > 7'd99) ? 7'd99 : raw;
      if (v >= 7'd10) begin
        h = {digit_segments(int'(v % 7'd10)), digit_segments(int'(v / 7'd10))};
      end else begin
        h = {digit_segments(int'(v)), lz ? digit_segments(0) : 8'h00};
      end
      h[15] = h[15] | colon;
      return h;
    endfunction

    function void push_word(bit [31:0] w, bit last);
      out_item_t e;
      e.command_word = w;
      e.last         = last;
      awaited.push_back(e);
    endfunction

    // Data word, optional upper-bytes word, then display-on with brightness.
    function void push_write(int start, bit [31:0] segs, bit four);
      bit [7:0] addr;
      addr = CMD_ADDRESS + 8'(start);
      push_word({segs[15:0], addr, CMD_WRITEMODE}, 1'b0);
      if (four) push_word({segs[31:16], 16'h0000}, 1'b0);
      push_word({24'd0, CMD_DISPLAY_ON + {5'd0, level}}, 1'b1);
    endfunction

    function void note_command(in_item_t it);
      bit        neg;
      bit [31:0] t;
      bit [31:0] mag;
      bit [31:0] segs;
      int        len;
      int        start;
      commands_seen++;
      case (it.func)
        FUNC_NUMBER: begin
          t   = it.number;
          neg = t[31];
          mag = neg ? (~t + 32'd1) : t;
          len = 0;
          t   = mag;
          while (t != 0) begin
            len++;
            t = t / 10;
          end
          if (len > (neg ? DIGITS - 1 : DIGITS)) len = neg ? DIGITS - 1 : DIGITS;
          segs = glyph_string(mag);
          if (neg) begin
            segs = {segs[23:0], GLYPH_MINUS};
            len++;
          end
          start = 0;
          if (it.leading_zeros && len < DIGITS) begin
            while (len < DIGITS) begin
              segs = {segs[23:0], digit_segments(0)};
              len++;
            end
          end else if (mag == 0) begin
            segs  = {24'd0, digit_segments(0)};
            start = DIGITS - 1;
          end else begin
            start = DIGITS - len;
          end
          push_write(start, segs, 1'b1);
        end
        FUNC_LEFT: begin
          push_write(0, {16'h0000, pair_segments(it.left_value, it.leading_zeros, colon_on)},
                     1'b0);
        end
        FUNC_RIGHT: begin
          push_write(2, {16'h0000, pair_segments(it.right_value, it.leading_zeros, 1'b0)},
                     1'b0);
        end
        FUNC_BOTH: begin
          push_write(0, {pair_segments(it.right_value, it.leading_zeros, 1'b0),
                         pair_segments(it.left_value, it.leading_zeros, colon_on)}, 1'b1);
        end
        FUNC_CLEAR: begin
          push_word(CLR_WORD0, 1'b0);
          push_word(CLR_WORD1, 1'b0);
          push_word(CLR_WORD2, 1'b1);
        end
        default: ignored_seen++;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      mismatches++;
    endtask

    task check_word(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("word %h last %b with nothing awaited",
                                  got.command_word, got.last));
        return;
      end
      want = awaited.pop_front();
      words_checked++;
      if (got.command_word !== want.command_word)
        report_mismatch($sformatf("command_word %h, predicted %h",
                                  got.command_word, want.command_word));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b on word %h, predicted %b",
                                  got.last, got.command_word, want.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cmd_valid;
  logic                  cmd_stall;
  in_item_t              cmd_data;
  logic                  word_valid;
  logic                  word_stall = 1'b0;
  out_item_t             word_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  segment_word_scoreboard board;

  // Idle mix of the current phase, in percent per cycle.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  // Register settings per random phase; both extremes of each register appear.
  bit [2:0] level_plan [8] = '{3'd7, 3'd0, 3'd3, 3'd7, 3'd5, 3'd0, 3'd1, 3'd6};
  bit       colon_plan [8] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  seven_segment_display_command_encoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (cmd_valid),
    .in_stall_o  (cmd_stall),
    .in_data_i   (cmd_data),
    .out_valid_o (word_valid),
    .out_stall_i (word_stall),
    .out_data_o  (word_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: stall at the phase's rate, changing only on the falling edge.
  always @(negedge clk) begin
    word_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sample both channels at the rising edge: note accepted commands, check
  // accepted words, and count quiet cycles for the hang watchdog.
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cmd_valid && !cmd_stall) begin
        board.note_command(cmd_data);
        moved = 1'b1;
      end
      if (word_valid && !word_stall) begin
        board.check_word(word_data);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic in_item_t make_cmd(logic [2:0] f, int n, bit lz, int lv, int rv);
    in_item_t it;
    it.func          = f;
    it.number        = n;
    it.leading_zeros = lz;
    it.left_value    = 7'(lv);
    it.right_value   = 7'(rv);
    return it;
  endfunction

  // Mostly well-formed commands with values biased towards digit-count edges,
  // plus clamped pair values and the odd spare code.
  function automatic in_item_t random_command();
    in_item_t  it;
    int        pick;
    int        k;
    bit [31:0] n;
    bit [31:0] p;
    pick = int'($urandom_range(99));
    if (pick < 40)      it.func = FUNC_NUMBER;
    else if (pick < 54) it.func = FUNC_LEFT;
    else if (pick < 68) it.func = FUNC_RIGHT;
    else if (pick < 84) it.func = FUNC_BOTH;
    else if (pick < 95) it.func = FUNC_CLEAR;
    else                it.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
    case ($urandom_range(4))
      0: n = $urandom();
      1: n = $urandom_range(9999);
      2: n = 32'd0 - $urandom_range(9999);
      3: n = $urandom_range(999999);
      default: begin
        k = int'($urandom_range(9));
        p = 32'd1;
        repeat (k) p = p * 10;
        n = p - 32'd1 + $urandom_range(1);
        if ($urandom_range(15) == 0) n = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    endcase
    if ($urandom_range(1)) n = ~n + 32'd1;
    it.number        = n;
    it.leading_zeros = 1'($urandom_range(1));
    it.left_value    = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                : 7'($urandom_range(99));
    it.right_value   = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                : 7'($urandom_range(99));
    return it;
  endfunction

  // Entered just after a falling edge; returns just after the falling edge that
  // follows the transfer, with valid still high.
  task automatic send_command(in_item_t item);
    bit [63:0] junk;
    if ($urandom_range(99) < send_idle_pct) begin
      junk = {$urandom, $urandom};
      cmd_valid <= 1'b0;
      cmd_data  <= junk[$bits(in_item_t)-1:0];
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= item;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  // Drop valid and hold off until every predicted word has arrived.
  task automatic drain(int extra);
    cmd_valid <= 1'b0;
    do @(negedge clk); while (board.awaited.size() != 0);
    repeat (extra) @(negedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic apply_settings(bit [2:0] level, bit colon);
    drain(DRAIN_CYCLES);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_BRIGHTNESS;
    cfg_data <= level;
    @(negedge clk);
    cfg_idx  <= CFG_COLON;
    cfg_data <= {2'b00, colon};
    @(negedge clk);
    cfg_we   <= 1'b0;
    board.level    = level;
    board.colon_on = colon;
  endtask

  initial begin : stimulus
    in_item_t item;
    int       issued;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    board     = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed commands under reset settings (brightness 0, colon lit).
    send_command(make_cmd(FUNC_NUMBER, 0, 1'b0, 0, 0));            // lone zero on digit 3
    send_command(make_cmd(FUNC_NUMBER, 0, 1'b1, 127, 127));        // four zero glyphs
    send_command(make_cmd(FUNC_NUMBER, 7, 1'b0, 0, 0));
    send_command(make_cmd(FUNC_NUMBER, 1234, 1'b0, 0, 0));
    send_command(make_cmd(FUNC_NUMBER, 42, 1'b1, 0, 0));
    send_command(make_cmd(FUNC_NUMBER, 98765, 1'b0, 0, 0));        // keep leading digits
    send_command(make_cmd(FUNC_NUMBER, 2147483647, 1'b0, 0, 0));
    send_command(make_cmd(FUNC_NUMBER, -5, 1'b0, 0, 0));
    send_command(make_cmd(FUNC_NUMBER, -5, 1'b1, 0, 0));           // zeros left of minus
    send_command(make_cmd(FUNC_NUMBER, -123, 1'b1, 0, 0));         // full width, no padding
    send_command(make_cmd(FUNC_NUMBER, -1000, 1'b0, 0, 0));        // negative, too long
    send_command(make_cmd(FUNC_NUMBER, 32'h8000_0000, 1'b0, 0, 0)); // most negative
    send_command(make_cmd(FUNC_LEFT, 0, 1'b0, 0, 0));
    send_command(make_cmd(FUNC_LEFT, 0, 1'b1, 5, 0));
    send_command(make_cmd(FUNC_LEFT, 0, 1'b0, 99, 0));
    send_command(make_cmd(FUNC_LEFT, 0, 1'b1, 127, 0));            // clamped to 99
    send_command(make_cmd(FUNC_RIGHT, 0, 1'b1, 0, 0));
    send_command(make_cmd(FUNC_RIGHT, 0, 1'b0, 0, 9));
    send_command(make_cmd(FUNC_RIGHT, 0, 1'b0, 0, 100));
    send_command(make_cmd(FUNC_BOTH, 0, 1'b0, 7, 123));
    send_command(make_cmd(FUNC_BOTH, 0, 1'b1, 0, 56));
    send_command(make_cmd(FUNC_CLEAR, 0, 1'b0, 0, 0));
    send_command(make_cmd(FUNC_SPARE_LO, -1, 1'b1, 127, 127));     // ignored code
    send_command(make_cmd(FUNC_SPARE_HI, 0, 1'b0, 0, 0));          // ignored code

    // Random phases: each idle/stall mix runs under two register settings.
    for (int phase = 0; phase < 8; phase++) begin
      apply_settings(level_plan[phase], colon_plan[phase]);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 50;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 50;
        end
        default: begin
          send_idle_pct = 33;
          stall_pct     = 33;
        end
      endcase
      issued = 0;
      while (issued < PHASE_COMMANDS) begin
        item = random_command();
        send_command(item);
        if (item.func <= FUNC_CLEAR) issued++;
        // Now and then hold off until the block has emptied completely.
        if ($urandom_range(24) == 0) drain(0);
      end
    end

    drain(DRAIN_CYCLES);
    $display("Covered %0d commands (%0d on spare codes) and %0d checked words,",
             board.commands_seen, board.ignored_seen, board.words_checked);
    $display("across nine brightness/colon settings and four idle/stall mixes.");
    if (board.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
